// ===== design/qle_pkg.sv =====
// ----------------------------------------------------------------------------
// qle_pkg
// types and constants shared by the q-learning engine modules
// ----------------------------------------------------------------------------
package qle_pkg;

  typedef enum logic [1:0] {
    REQ_CHOOSE  = 2'd0,
    REQ_UPDATE  = 2'd1,
    REQ_EPISODE = 2'd2
  } req_type_e;

  typedef enum logic [1:0] {
    CFG_LEARNING_RATE = 2'd0,
    CFG_DISCOUNT      = 2'd1,
    CFG_START_EXPLORE = 2'd2,
    CFG_RANDOM_SEED   = 2'd3
  } cfg_reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_DRAW2,
    ST_MOD,
    ST_SCAN,
    ST_RD_CUR,
    ST_MUL1,
    ST_TD,
    ST_MUL2,
    ST_WRITE,
    ST_DECAY,
    ST_DONE
  } state_e;

  localparam logic [15:0] LR_RESET      = 16'd6554;
  localparam logic [15:0] DISCOUNT_RESET = 16'd58982;
  localparam logic [15:0] EXPLORE_RESET = 16'd6554;
  localparam logic [15:0] SEED_RESET    = 16'd44257;
  localparam logic [15:0] DECAY_FACTOR  = 16'd65208;
  localparam logic [15:0] EXPLORE_FLOOR = 16'd655;
  localparam logic [15:0] LFSR_MASK     = 16'hB400;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [3:0]         rtt_level;
    logic [1:0]         priority_level;
    logic [2:0]         taken_action;
    logic signed [31:0] reward_value;
    logic [3:0]         next_rtt_level;
    logic [1:0]         next_priority_level;
  } req_t;

  typedef struct packed {
    logic [2:0]         chosen_action;
    logic               explored;
    logic               status;
    logic signed [31:0] new_q_value;
    logic [15:0]        current_explore_rate;
  } rsp_t;

  typedef struct packed {
    logic load;
    logic decode;
    logic draw2;
    logic mod_step;
    logic scan;
    logic rd_cur;
    logic mul1;
    logic td;
    logic mul2;
    logic write;
    logic decay;
  } cmd_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic       cur_ok;
    logic       upd_ok;
    logic       explore_hit;
    logic       scan_last;
  } stat_t;

  // galois lfsr, shifting right
  function automatic logic [15:0] lfsr_step(input logic [15:0] s);
    logic [15:0] n;
    n = {1'b0, s[15:1]};
    if (s[0]) begin
      n = n ^ LFSR_MASK;
    end
    return n;
  endfunction

endpackage

// ===== design/tabular_q_learning_engine.sv =====
// ----------------------------------------------------------------------------
// tabular_q_learning_engine
// epsilon-greedy tabular q-learning with on-chip value table
// ----------------------------------------------------------------------------
// A request word is taken on req_i when start is high and busy is low.
// busy stays high until the result word has been shown: done_o pulses for
// one cycle with rsp_o valid, and the block is ready again the cycle after.
// The receiver cannot stall; the result is simply sampled on the done_o cycle.
// Steps from accept to done_o: a greedy choose decodes and scans the row; an
// explored choose takes a second draw, then reduces it mod ACTION_COUNT with
// a reciprocal multiply; an update scans the row of the next state, then does
// two registered multiplies and a read-modify-write of the current row; an
// episode end decodes, then takes the decay step; rejected or unknown requests decode only.
// The table is a row memory, one action row per word, read one port a cycle.
// Configuration writes go through cfg_valid_i/cfg_ready_o (always ready) and
// must be issued while the block is idle. Reset zeroes the table through
// per-row valid bits, restores register defaults and needs no clearing pass.
// ----------------------------------------------------------------------------
module tabular_q_learning_engine #(
  parameter int RTT_LEVELS      = 4,
  parameter int PRIORITY_LEVELS = 3,
  parameter int ACTION_COUNT    = 4,
  parameter int DECAY_PERIOD    = 100
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  qle_pkg::req_t req_i,
  output logic          done_o,
  output qle_pkg::rsp_t rsp_o,
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic [1:0]    cfg_index_i,
  input  logic [15:0]   cfg_data_i
);

  qle_pkg::cmd_t  cmd;
  qle_pkg::stat_t stat;

  assign cfg_ready_o = 1'b1;

  qle_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .done_o (done_o),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  qle_dp #(
    .RTT_LEVELS      (RTT_LEVELS),
    .PRIORITY_LEVELS (PRIORITY_LEVELS),
    .ACTION_COUNT    (ACTION_COUNT),
    .DECAY_PERIOD    (DECAY_PERIOD)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .rsp_o       (rsp_o)
  );

  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy) else $error("done outside busy");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !busy) else $error("no return to idle after done");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("accepted word did not raise busy");

  a_bad_no_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.status) |-> (rsp_o.new_q_value == '0 && !rsp_o.explored))
    else $error("rejected request carries a result");

  a_explore_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.explored) |-> (rsp_o.new_q_value == '0))
    else $error("explored choose carries a table value");

endmodule

// ===== design/qle_ctrl.sv =====
// ----------------------------------------------------------------------------
// qle_ctrl
// request sequencer: steps the datapath through decode, explore draw and modulo, scan, decay, arithmetic
// ----------------------------------------------------------------------------
module qle_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  output logic           done_o,
  input  qle_pkg::stat_t stat_i,
  output qle_pkg::cmd_t  cmd_o
);

  qle_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= qle_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      qle_pkg::ST_IDLE: begin
        if (start) begin
          state_d = qle_pkg::ST_DECODE;
        end
      end
      qle_pkg::ST_DECODE: begin
        case (stat_i.req_type)
          qle_pkg::REQ_CHOOSE: begin
            if (!stat_i.cur_ok) begin
              state_d = qle_pkg::ST_DONE;
            end else if (stat_i.explore_hit) begin
              state_d = qle_pkg::ST_DRAW2;
            end else begin
              state_d = qle_pkg::ST_SCAN;
            end
          end
          qle_pkg::REQ_UPDATE: begin
            state_d = stat_i.upd_ok ? qle_pkg::ST_SCAN : qle_pkg::ST_DONE;
          end
          qle_pkg::REQ_EPISODE: state_d = qle_pkg::ST_DECAY;
          default: state_d = qle_pkg::ST_DONE;
        endcase
      end
      qle_pkg::ST_DRAW2: state_d = qle_pkg::ST_MOD;
      qle_pkg::ST_MOD:   state_d = qle_pkg::ST_DONE;
      qle_pkg::ST_SCAN: begin
        if (stat_i.scan_last) begin
          state_d = (stat_i.req_type == qle_pkg::REQ_CHOOSE) ? qle_pkg::ST_DONE
                                                             : qle_pkg::ST_RD_CUR;
        end
      end
      qle_pkg::ST_RD_CUR: state_d = qle_pkg::ST_MUL1;
      qle_pkg::ST_MUL1:   state_d = qle_pkg::ST_TD;
      qle_pkg::ST_TD:     state_d = qle_pkg::ST_MUL2;
      qle_pkg::ST_MUL2:   state_d = qle_pkg::ST_WRITE;
      qle_pkg::ST_WRITE:  state_d = qle_pkg::ST_DONE;
      qle_pkg::ST_DECAY:  state_d = qle_pkg::ST_DONE;
      qle_pkg::ST_DONE:   state_d = qle_pkg::ST_IDLE;
      default:            state_d = qle_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o  = '0;
    busy   = 1'b1;
    done_o = 1'b0;
    case (state_q)
      qle_pkg::ST_IDLE: begin
        busy       = 1'b0;
        cmd_o.load = start;
      end
      qle_pkg::ST_DECODE: cmd_o.decode   = 1'b1;
      qle_pkg::ST_DRAW2:  cmd_o.draw2    = 1'b1;
      qle_pkg::ST_MOD:    cmd_o.mod_step = 1'b1;
      qle_pkg::ST_SCAN:   cmd_o.scan     = 1'b1;
      qle_pkg::ST_RD_CUR: cmd_o.rd_cur   = 1'b1;
      qle_pkg::ST_MUL1:   cmd_o.mul1     = 1'b1;
      qle_pkg::ST_TD:     cmd_o.td       = 1'b1;
      qle_pkg::ST_MUL2:   cmd_o.mul2     = 1'b1;
      qle_pkg::ST_WRITE:  cmd_o.write    = 1'b1;
      qle_pkg::ST_DECAY:  cmd_o.decay    = 1'b1;
      qle_pkg::ST_DONE:   done_o         = 1'b1;
      default:            busy           = 1'b1;
    endcase
  end

endmodule

// ===== design/qle_dp.sv =====
// ----------------------------------------------------------------------------
// qle_dp
// q table row memory, lfsr, explore rate, scan and td arithmetic
// ----------------------------------------------------------------------------
module qle_dp #(
  parameter int RTT_LEVELS      = 4,
  parameter int PRIORITY_LEVELS = 3,
  parameter int ACTION_COUNT    = 4,
  parameter int DECAY_PERIOD    = 100
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  qle_pkg::req_t  req_i,
  input  logic           cfg_we_i,
  input  logic [1:0]     cfg_index_i,
  input  logic [15:0]    cfg_data_i,
  input  qle_pkg::cmd_t  cmd_i,
  output qle_pkg::stat_t stat_o,
  output qle_pkg::rsp_t  rsp_o
);

  localparam int NROWS = RTT_LEVELS * PRIORITY_LEVELS;
  localparam int RW    = $clog2(NROWS);
  localparam int AW    = $clog2(ACTION_COUNT);
  localparam int DW    = $clog2(DECAY_PERIOD + 1);
  // reciprocal for an exact 16-bit remainder by the action count
  localparam int RSH   = 16 + AW;
  localparam int RECIP = (2 ** RSH + ACTION_COUNT - 1) / ACTION_COUNT;

  typedef logic [ACTION_COUNT-1:0][31:0] row_t;

  // configuration and persistent state
  logic [15:0] lr_q, gamma_q, rate_q, lfsr_q;
  logic [31:0] ep_cnt_q;
  logic [DW-1:0] ep_mod_q;
  logic        decay_hit_q;

  // item
  qle_pkg::req_t it_q;
  logic cur_ok_q, upd_ok_q;
  logic [RW-1:0] cur_row_q, nxt_row_q;

  // table
  row_t mem_q [NROWS];
  logic [NROWS-1:0] vld_q;
  row_t rd_row_q;
  logic rd_vld_q;
  row_t row_eff;
  logic rd_en;
  logic [RW-1:0] rd_addr;

  // scan and arithmetic
  logic [AW-1:0] sc_q, best_idx_q, win_idx;
  logic signed [31:0] best_val_q, sc_val, old_val;
  logic signed [48:0] p_q, p_rnd;
  logic signed [34:0] td_q, td_d;
  logic signed [51:0] m2_q, m2_rnd;
  logic signed [36:0] nv;
  logic signed [31:0] nv_sat;
  logic [AW-1:0] act;

  // explore modulo
  logic [15:0] sh_q;
  logic [35:0] mod_prod;
  logic [15:0] mod_quo, mod_rem;

  // results
  logic [2:0] chosen_q;
  logic explored_q, status_q;
  logic signed [31:0] newq_q;

  logic [15:0] lfsr_nx;
  logic [7:0] cur_lin, nxt_lin;
  logic cur_in, upd_in;
  logic [31:0] ep_cnt_n;
  logic [DW-1:0] ep_mod_n;
  logic [32:0] dec_p;
  logic [16:0] dec_e;

  assign lfsr_nx = qle_pkg::lfsr_step(lfsr_q);
  assign act     = it_q.taken_action[AW-1:0];

  assign cur_lin = 8'(req_i.rtt_level) * 8'(PRIORITY_LEVELS) + 8'(req_i.priority_level);
  assign nxt_lin = 8'(req_i.next_rtt_level) * 8'(PRIORITY_LEVELS)
                 + 8'(req_i.next_priority_level);
  assign cur_in  = ({1'b0, req_i.rtt_level} < 5'(RTT_LEVELS))
                && ({1'b0, req_i.priority_level} < 3'(PRIORITY_LEVELS));
  assign upd_in  = cur_in
                && ({1'b0, req_i.taken_action} < 4'(ACTION_COUNT))
                && ({1'b0, req_i.next_rtt_level} < 5'(RTT_LEVELS))
                && ({1'b0, req_i.next_priority_level} < 3'(PRIORITY_LEVELS));

  assign stat_o.req_type    = it_q.req_type;
  assign stat_o.cur_ok      = cur_ok_q;
  assign stat_o.upd_ok      = upd_ok_q;
  assign stat_o.explore_hit = lfsr_nx < rate_q;
  assign stat_o.scan_last   = sc_q == AW'(ACTION_COUNT - 1);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      it_q      <= req_i;
      cur_row_q <= cur_lin[RW-1:0];
      nxt_row_q <= nxt_lin[RW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_ok_q <= 1'b0;
      upd_ok_q <= 1'b0;
    end else if (cmd_i.load) begin
      cur_ok_q <= cur_in;
      upd_ok_q <= upd_in;
    end
  end

  // row memory; a row never written reads as zero
  assign rd_en   = cmd_i.decode || cmd_i.rd_cur;
  assign rd_addr = (cmd_i.decode && it_q.req_type == qle_pkg::REQ_UPDATE) ? nxt_row_q
                                                                           : cur_row_q;
  assign row_eff = rd_vld_q ? rd_row_q : '0;

  function automatic row_t row_new();
    row_t w;
    w      = row_eff;
    w[act] = nv_sat;
    return w;
  endfunction

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_row_q <= mem_q[rd_addr];
    end
    if (cmd_i.write) begin
      mem_q[cur_row_q] <= row_new();
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (rd_en) begin
        rd_vld_q <= vld_q[rd_addr];
      end
      if (cmd_i.write) begin
        vld_q[cur_row_q] <= 1'b1;
      end
    end
  end

  // greedy scan, strict compare keeps the lowest index on ties
  assign sc_val  = row_eff[sc_q];
  assign win_idx = (sc_val > best_val_q) ? sc_q : best_idx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sc_q <= '0;
    end else if (cmd_i.scan) begin
      sc_q <= stat_o.scan_last ? '0 : sc_q + AW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan) begin
      if (sc_q == '0) begin
        best_idx_q <= '0;
        best_val_q <= sc_val;
      end else if (sc_val > best_val_q) begin
        best_idx_q <= sc_q;
        best_val_q <= sc_val;
      end
    end
  end

  // td update: two multiplies, each registered
  assign old_val = row_eff[act];
  assign p_rnd   = p_q + 49'sd32768;
  assign td_d    = $signed({{3{it_q.reward_value[31]}}, it_q.reward_value})
                 + $signed({{2{p_rnd[48]}}, p_rnd[48:16]})
                 - $signed({{3{old_val[31]}}, old_val});
  assign m2_rnd  = m2_q + 52'sd32768;
  assign nv      = $signed({{5{old_val[31]}}, old_val})
                 + $signed({m2_rnd[51], m2_rnd[51:16]});

  always_comb begin
    if (nv > 37'sd2147483647) begin
      nv_sat = 32'sh7FFFFFFF;
    end else if (nv < -37'sd2147483648) begin
      nv_sat = 32'sh80000000;
    end else begin
      nv_sat = nv[31:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul1) begin
      p_q <= $signed({1'b0, gamma_q}) * best_val_q;
    end
    if (cmd_i.td) begin
      td_q <= td_d;
    end
    if (cmd_i.mul2) begin
      m2_q <= $signed({1'b0, lr_q}) * td_q;
    end
  end

  // random action: second draw reduced mod action count by reciprocal multiply
  assign mod_prod = 36'(sh_q) * 36'(RECIP);
  assign mod_quo  = mod_prod[RSH +: 16];
  assign mod_rem  = sh_q - mod_quo * 16'(ACTION_COUNT);

  always_ff @(posedge clk_i) begin
    if (cmd_i.draw2) begin
      sh_q <= lfsr_nx;
    end
  end

  // episode counting and explore decay
  assign ep_cnt_n = ep_cnt_q + 32'd1;
  assign ep_mod_n = (ep_cnt_n == '0 || ep_mod_q == DW'(DECAY_PERIOD - 1)) ? '0
                                                                          : ep_mod_q + DW'(1);
  assign dec_p    = 33'(32'(rate_q) * 32'(qle_pkg::DECAY_FACTOR)) + 33'd32768;
  assign dec_e    = dec_p[32:16];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lr_q        <= qle_pkg::LR_RESET;
      gamma_q     <= qle_pkg::DISCOUNT_RESET;
      rate_q      <= qle_pkg::EXPLORE_RESET;
      lfsr_q      <= qle_pkg::SEED_RESET;
      ep_cnt_q    <= '0;
      ep_mod_q    <= '0;
      decay_hit_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          qle_pkg::CFG_LEARNING_RATE: lr_q    <= cfg_data_i;
          qle_pkg::CFG_DISCOUNT:      gamma_q <= cfg_data_i;
          qle_pkg::CFG_START_EXPLORE: rate_q  <= cfg_data_i;
          qle_pkg::CFG_RANDOM_SEED:   lfsr_q  <= (cfg_data_i == '0) ? 16'd1 : cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.decode && it_q.req_type == qle_pkg::REQ_CHOOSE && cur_ok_q) begin
        lfsr_q <= lfsr_nx;
      end
      if (cmd_i.draw2) begin
        lfsr_q <= lfsr_nx;
      end
      if (cmd_i.decode && it_q.req_type == qle_pkg::REQ_EPISODE) begin
        ep_cnt_q    <= ep_cnt_n;
        ep_mod_q    <= ep_mod_n;
        decay_hit_q <= (ep_cnt_n != '0) && (ep_mod_n == '0);
      end
      if (cmd_i.decay && decay_hit_q) begin
        rate_q <= (dec_e < 17'(qle_pkg::EXPLORE_FLOOR)) ? qle_pkg::EXPLORE_FLOOR
                                                        : dec_e[15:0];
      end
    end
  end

  // result word
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      chosen_q   <= '0;
      explored_q <= 1'b0;
      status_q   <= 1'b0;
      newq_q     <= '0;
    end
    if (cmd_i.decode) begin
      case (it_q.req_type)
        qle_pkg::REQ_CHOOSE: begin
          status_q   <= !cur_ok_q;
          explored_q <= cur_ok_q && stat_o.explore_hit;
        end
        qle_pkg::REQ_UPDATE:  status_q <= !upd_ok_q;
        qle_pkg::REQ_EPISODE: status_q <= 1'b0;
        default:              status_q <= 1'b1;
      endcase
    end
    if (cmd_i.mod_step) begin
      chosen_q <= 3'(mod_rem);
    end
    if (cmd_i.scan && stat_o.scan_last && it_q.req_type == qle_pkg::REQ_CHOOSE) begin
      chosen_q <= 3'(win_idx);
    end
    if (cmd_i.write) begin
      newq_q <= nv_sat;
    end
  end

  assign rsp_o.chosen_action        = chosen_q;
  assign rsp_o.explored             = explored_q;
  assign rsp_o.status               = status_q;
  assign rsp_o.new_q_value          = newq_q;
  assign rsp_o.current_explore_rate = rate_q;

endmodule
